>>> hdl/hdep_pkg.sv
// shared types, character codes and calendar tables for the http date parser
`default_nettype none

package hdep_pkg;

   localparam int EPOCH_W = 39;

   // ascii codes seen by the parser
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_J  = 8'h4A;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_M  = 8'h4D;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_S  = 8'h53;
   localparam logic [7:0] CH_UP_O  = 8'h4F;
   localparam logic [7:0] CH_UP_N  = 8'h4E;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_N  = 8'h6E;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_P  = 8'h70;

   localparam logic [3:0] MON_JAN = 4'd0;
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_MAR = 4'd2;
   localparam logic [3:0] MON_APR = 4'd3;
   localparam logic [3:0] MON_MAY = 4'd4;
   localparam logic [3:0] MON_JUN = 4'd5;
   localparam logic [3:0] MON_JUL = 4'd6;
   localparam logic [3:0] MON_AUG = 4'd7;
   localparam logic [3:0] MON_SEP = 4'd8;
   localparam logic [3:0] MON_OCT = 4'd9;
   localparam logic [3:0] MON_NOV = 4'd10;
   localparam logic [3:0] MON_DEC = 4'd11;

   // floor(x / 100) == (x * 5243) >> 19 for x below 10400
   localparam logic [16:0] RECIP_100  = 17'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [16:0] MUL_100    = 17'd100;
   localparam logic [16:0] MUL_YEAR   = 17'd365;
   localparam logic [16:0] MUL_DAY    = 17'd86400;
   localparam logic [16:0] MUL_HOUR   = 17'd3600;
   localparam logic [16:0] MUL_MIN    = 17'd60;

   // -146097 - 31 - 719527 + 31 + 28: fixed part of the day count
   localparam logic signed [39:0] DAY_BASE = -40'sd865596;

   localparam logic [13:0] YEAR_BASE  = 14'd400;
   localparam logic [13:0] YEAR_LIMIT = 14'd2038;
   localparam logic [13:0] PIVOT      = 14'd70;
   localparam logic [13:0] CENT_20    = 14'd2000;
   localparam logic [13:0] CENT_19    = 14'd1900;

   typedef enum logic [5:0] {
      PH_WDAY   = 6'd0,
      PH_SKIP   = 6'd1,
      PH_DAY0   = 6'd2,
      PH_DAY1   = 6'd3,
      PH_DAYSEP = 6'd4,
      PH_MON0   = 6'd5,
      PH_MON1   = 6'd6,
      PH_MON2   = 6'd7,
      PH_MONSEP = 6'd8,
      PH_Y4_0   = 6'd9,
      PH_Y4_1   = 6'd10,
      PH_Y4_2   = 6'd11,
      PH_Y4_3   = 6'd12,
      PH_Y2_0   = 6'd13,
      PH_Y2_1   = 6'd14,
      PH_IDAY0  = 6'd15,
      PH_IDAY0B = 6'd16,
      PH_IDAY1  = 6'd17,
      PH_TSEP   = 6'd18,
      PH_H0     = 6'd19,
      PH_H1     = 6'd20,
      PH_C1     = 6'd21,
      PH_M0     = 6'd22,
      PH_M1     = 6'd23,
      PH_C2     = 6'd24,
      PH_S0     = 6'd25,
      PH_S1     = 6'd26,
      PH_YSEP   = 6'd27,
      PH_DONE   = 6'd28
   } parse_phase_type;

   typedef enum logic [1:0] {
      LAY_NONE = 2'd0,
      LAY_822  = 2'd1,
      LAY_850  = 2'd2,
      LAY_ASC  = 2'd3
   } date_layout_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DIV_Y,
      CS_DIV_YY,
      CS_CENT,
      CS_MUL_YEAR,
      CS_SUB_C,
      CS_ADD_Q,
      CS_ADD_DAYS,
      CS_MUL_DAY,
      CS_MUL_HOUR,
      CS_MUL_MIN,
      CS_ADD_MIN,
      CS_FIN
   } calc_step_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         MON_FEB: len = 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // 367 * mm / 12 with march as mm 1
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] ofs;
      unique case (m)
         MON_JAN: ofs = 9'd336;
         MON_FEB: ofs = 9'd367;
         MON_MAR: ofs = 9'd30;
         MON_APR: ofs = 9'd61;
         MON_MAY: ofs = 9'd91;
         MON_JUN: ofs = 9'd122;
         MON_JUL: ofs = 9'd152;
         MON_AUG: ofs = 9'd183;
         MON_SEP: ofs = 9'd214;
         MON_OCT: ofs = 9'd244;
         MON_NOV: ofs = 9'd275;
         MON_DEC: ofs = 9'd305;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

>>> hdl/http_date_to_epoch_parser.sv
// http date header parser with iterative epoch seconds conversion
//
// req_ channel: one character per item, req_last_byte marks the end of the
// value. characters of a date are taken one per cycle while req_stall is low.
// rsp_ channel: one item per value, sent after its last character:
// rsp_date_valid and signed rsp_epoch_seconds (zero when not valid).
// csr_ channel: writes the single limit_to_2037 bit; csr_ready is always high.
//
// after the last character the block runs a 12-step sequence on one shared
// multiplier and one 40-bit adder (divide by 100 through a reciprocal, day
// count, then days, hours and minutes scaled to seconds). req_stall is high
// from the first step until the final step loads the result item, which it
// does only once the output register is free. a result waits in the output
// register while rsp_stall is high and parsing of the next value goes on;
// only the final step of the next value waits for the register to drain.
// reset clears the parse state, the sequencer, the output valid and the
// limit bit.
`default_nettype none

module http_date_to_epoch_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_text_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_date_valid,
   output logic signed [hdep_pkg::EPOCH_W-1:0] rsp_epoch_seconds,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_limit_to_2037
);
   import hdep_pkg::*;

   // parse state
   parse_phase_type phase_ff, phase_in;
   date_layout_type layout_ff, layout_in;
   logic        failed_ff, failed_in;
   logic [6:0]  day_ff, day_in;
   logic [7:0]  mon_c0_ff, mon_c0_in;
   logic [7:0]  mon_c1_ff, mon_c1_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        limit_ff, limit_in;

   // sequencer and shared unit
   calc_step_type       step_ff, step_in;
   logic signed [24:0]  mul_a;
   logic [16:0]         mul_b;
   logic                prod_en;
   logic signed [42:0]  prod_ff, prod_in;
   logic                acc_clr;
   logic signed [39:0]  add_b;
   logic signed [39:0]  acc_ff, acc_in;
   logic [6:0]          y100_ff, y100_in;
   logic [6:0]          yy100_ff, yy100_in;
   logic                cent_ff, cent_in;
   logic [13:0]         yy;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_date_valid_ff, rsp_date_valid_in;
   logic signed [EPOCH_W-1:0] rsp_epoch_ff, rsp_epoch_in;

   logic        req_take;
   logic        out_busy;
   logic        fin_go;
   logic        date_ok;
   logic        feb29;
   logic        leap;

   // parse helpers
   logic [7:0]      c;
   logic            dig;
   logic [3:0]      dv;
   logic            act;
   parse_phase_type ph;
   logic [6:0]      day_dig, hour_dig, minute_dig, second_dig;
   logic [13:0]     year_dig;

   assign req_stall = (step_ff != CS_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign fin_go    = (step_ff == CS_FIN) && !out_busy;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_date_valid    = rsp_date_valid_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

   assign c          = req_text_byte;
   assign dig        = (c >= CH_ZERO) && (c <= CH_NINE);
   assign dv         = c[3:0];
   assign day_dig    = 7'(11'(day_ff) * 11'd10 + 11'(dv));
   assign hour_dig   = 7'(11'(hour_ff) * 11'd10 + 11'(dv));
   assign minute_dig = 7'(11'(minute_ff) * 11'd10 + 11'(dv));
   assign second_dig = 7'(11'(second_ff) * 11'd10 + 11'(dv));
   assign year_dig   = 14'(18'(year_ff) * 18'd10 + 18'(dv));

   assign limit_in = (csr_valid && csr_ready) ? csr_limit_to_2037 : limit_ff;

   // character parser
   always_comb begin
      phase_in  = phase_ff;
      layout_in = layout_ff;
      failed_in = failed_ff;
      day_in    = day_ff;
      mon_c0_in = mon_c0_ff;
      mon_c1_in = mon_c1_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      ph        = phase_ff;
      act       = 1'b0;

      if (req_take && !failed_ff && (phase_ff != PH_DONE)) begin
         act = 1'b1;
         // spaces after the weekday separator are dropped
         if (phase_ff == PH_SKIP) begin
            if (c == CH_SPACE) begin
               act = 1'b0;
            end else begin
               ph       = (layout_ff == LAY_ASC) ? PH_MON0 : PH_DAY0;
               phase_in = ph;
            end
         end
      end

      if (act) begin
         unique case (ph)
            PH_WDAY: begin
               if (c == CH_COMMA) begin
                  phase_in = PH_SKIP;
               end else if (c == CH_SPACE) begin
                  layout_in = LAY_ASC;
                  phase_in  = PH_SKIP;
               end
            end
            PH_DAY0, PH_DAY1: begin
               if (dig) begin
                  day_in   = day_dig;
                  phase_in = (ph == PH_DAY0) ? PH_DAY1 : PH_DAYSEP;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_DAYSEP: begin
               if (c == CH_SPACE) begin
                  layout_in = LAY_822;
                  phase_in  = PH_MON0;
               end else if (c == CH_DASH) begin
                  layout_in = LAY_850;
                  phase_in  = PH_MON0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_MON0: begin
               if (c == CH_UP_J || c == CH_UP_F || c == CH_UP_M || c == CH_UP_A ||
                   c == CH_UP_S || c == CH_UP_O || c == CH_UP_N || c == CH_UP_D) begin
                  mon_c0_in = c;
                  phase_in  = PH_MON1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_MON1: begin
               mon_c1_in = c;
               phase_in  = PH_MON2;
            end
            PH_MON2: begin
               // month from first letter, then second or third where needed
               priority if (mon_c0_ff == CH_UP_J) begin
                  month_in = (mon_c1_ff == CH_LO_A) ? MON_JAN :
                             (c == CH_LO_N) ? MON_JUN : MON_JUL;
               end else if (mon_c0_ff == CH_UP_F) begin
                  month_in = MON_FEB;
               end else if (mon_c0_ff == CH_UP_M) begin
                  month_in = (c == CH_LO_R) ? MON_MAR : MON_MAY;
               end else if (mon_c0_ff == CH_UP_A) begin
                  month_in = (mon_c1_ff == CH_LO_P) ? MON_APR : MON_AUG;
               end else if (mon_c0_ff == CH_UP_S) begin
                  month_in = MON_SEP;
               end else if (mon_c0_ff == CH_UP_O) begin
                  month_in = MON_OCT;
               end else if (mon_c0_ff == CH_UP_N) begin
                  month_in = MON_NOV;
               end else begin
                  month_in = MON_DEC;
               end
               phase_in = PH_MONSEP;
            end
            PH_MONSEP: begin
               if (c == ((layout_ff == LAY_850) ? CH_DASH : CH_SPACE)) begin
                  phase_in = (layout_ff == LAY_822) ? PH_Y4_0 :
                             (layout_ff == LAY_850) ? PH_Y2_0 : PH_IDAY0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_Y4_0, PH_Y4_1, PH_Y4_2, PH_Y2_0: begin
               if (dig) begin
                  year_in  = year_dig;
                  phase_in = (ph == PH_Y4_0) ? PH_Y4_1 :
                             (ph == PH_Y4_1) ? PH_Y4_2 :
                             (ph == PH_Y4_2) ? PH_Y4_3 : PH_Y2_1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_Y4_3: begin
               if (dig) begin
                  year_in  = year_dig;
                  phase_in = (layout_ff == LAY_ASC) ? PH_DONE : PH_TSEP;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_Y2_1: begin
               // two-digit year pivots at 70
               if (dig) begin
                  year_in  = year_dig + ((year_dig < PIVOT) ? CENT_20 : CENT_19);
                  phase_in = PH_TSEP;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_IDAY0: begin
               if (c == CH_SPACE) begin
                  phase_in = PH_IDAY0B;
               end else if (dig) begin
                  day_in   = day_dig;
                  phase_in = PH_IDAY1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_IDAY0B: begin
               if (dig) begin
                  day_in   = day_dig;
                  phase_in = PH_IDAY1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_IDAY1: begin
               if (c == CH_SPACE) begin
                  phase_in = PH_H0;
               end else if (dig) begin
                  day_in   = day_dig;
                  phase_in = PH_TSEP;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_TSEP, PH_YSEP: begin
               if (c == CH_SPACE) begin
                  phase_in = (ph == PH_TSEP) ? PH_H0 : PH_Y4_0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_H0, PH_H1: begin
               if (dig) begin
                  hour_in  = hour_dig;
                  phase_in = (ph == PH_H0) ? PH_H1 : PH_C1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_C1, PH_C2: begin
               if (c == CH_COLON) begin
                  phase_in = (ph == PH_C1) ? PH_M0 : PH_S0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_M0, PH_M1: begin
               if (dig) begin
                  minute_in = minute_dig;
                  phase_in  = (ph == PH_M0) ? PH_M1 : PH_C2;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_S0: begin
               if (dig) begin
                  second_in = second_dig;
                  phase_in  = PH_S1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_S1: begin
               if (dig) begin
                  second_in = second_dig;
                  phase_in  = (layout_ff == LAY_ASC) ? PH_YSEP : PH_DONE;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end

      // back to the start once the result is out
      if (fin_go) begin
         phase_in  = PH_WDAY;
         layout_in = LAY_NONE;
         failed_in = 1'b0;
         day_in    = '0;
         mon_c0_in = '0;
         mon_c1_in = '0;
         month_in  = '0;
         year_in   = '0;
         hour_in   = '0;
         minute_in = '0;
         second_in = '0;
      end
   end

   // sequencer next state
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         CS_IDLE:     if (req_take && req_last_byte) step_in = CS_DIV_Y;
         CS_DIV_Y:    step_in = CS_DIV_YY;
         CS_DIV_YY:   step_in = CS_CENT;
         CS_CENT:     step_in = CS_MUL_YEAR;
         CS_MUL_YEAR: step_in = CS_SUB_C;
         CS_SUB_C:    step_in = CS_ADD_Q;
         CS_ADD_Q:    step_in = CS_ADD_DAYS;
         CS_ADD_DAYS: step_in = CS_MUL_DAY;
         CS_MUL_DAY:  step_in = CS_MUL_HOUR;
         CS_MUL_HOUR: step_in = CS_MUL_MIN;
         CS_MUL_MIN:  step_in = CS_ADD_MIN;
         CS_ADD_MIN:  step_in = CS_FIN;
         CS_FIN:      if (!out_busy) step_in = CS_IDLE;
         default:     step_in = CS_IDLE;
      endcase
   end

   // year shifted to start in march, plus 400 to keep it positive
   assign yy = 14'(year_ff + YEAR_BASE - {13'b0, month_ff < MON_MAR});

   // sequencer controls for the shared multiplier and adder
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      prod_en  = 1'b0;
      acc_clr  = 1'b0;
      add_b    = '0;
      y100_in  = y100_ff;
      yy100_in = yy100_ff;
      cent_in  = cent_ff;
      unique case (step_ff)
         CS_IDLE: begin
         end
         CS_DIV_Y: begin
            mul_a   = $signed({11'b0, year_ff});
            mul_b   = RECIP_100;
            prod_en = 1'b1;
            acc_clr = 1'b1;
            add_b   = DAY_BASE;
         end
         CS_DIV_YY: begin
            y100_in = prod_ff[RECIP_SHIFT+6:RECIP_SHIFT];
            mul_a   = $signed({11'b0, yy});
            mul_b   = RECIP_100;
            prod_en = 1'b1;
            add_b   = $signed({33'b0, day_ff});
         end
         CS_CENT: begin
            yy100_in = prod_ff[RECIP_SHIFT+6:RECIP_SHIFT];
            mul_a    = $signed({18'b0, y100_ff});
            mul_b    = MUL_100;
            prod_en  = 1'b1;
            add_b    = $signed({31'b0, month_offset(month_ff)});
         end
         CS_MUL_YEAR: begin
            // year is a whole century when (year / 100) * 100 gives it back
            cent_in = (prod_ff == $signed({29'b0, year_ff}));
            mul_a   = $signed({11'b0, yy});
            mul_b   = MUL_YEAR;
            prod_en = 1'b1;
            add_b   = $signed({28'b0, yy[13:2]});
         end
         CS_SUB_C: begin
            add_b = -$signed({33'b0, yy100_ff});
         end
         CS_ADD_Q: begin
            add_b = $signed({35'b0, yy100_ff[6:2]});
         end
         CS_ADD_DAYS: begin
            add_b = prod_ff[39:0];
         end
         CS_MUL_DAY: begin
            mul_a   = acc_ff[24:0];
            mul_b   = MUL_DAY;
            prod_en = 1'b1;
         end
         CS_MUL_HOUR: begin
            mul_a   = $signed({18'b0, hour_ff});
            mul_b   = MUL_HOUR;
            prod_en = 1'b1;
            acc_clr = 1'b1;
            add_b   = prod_ff[39:0];
         end
         CS_MUL_MIN: begin
            mul_a   = $signed({18'b0, minute_ff});
            mul_b   = MUL_MIN;
            prod_en = 1'b1;
            add_b   = prod_ff[39:0];
         end
         CS_ADD_MIN: begin
            add_b = prod_ff[39:0];
         end
         CS_FIN: begin
            // seconds go in once, on the cycle the result is loaded
            if (fin_go) add_b = $signed({33'b0, second_ff});
         end
         default: begin
         end
      endcase
   end

   assign prod_in = prod_en ? (mul_a * $signed({1'b0, mul_b})) : prod_ff;
   assign acc_in  = (acc_clr ? 40'sd0 : acc_ff) + add_b;

   // date checks, done on the final step
   assign feb29 = (day_ff == 7'd29) && (month_ff == MON_FEB);
   assign leap  = (year_ff[1:0] == 2'b00) && !(cent_ff && (y100_ff[1:0] != 2'b00));

   always_comb begin
      date_ok = !failed_ff && (phase_ff == PH_DONE) && (month_ff <= MON_DEC)
                && (hour_ff <= 7'd23) && (minute_ff <= 7'd59) && (second_ff <= 7'd59)
                && (day_ff != 7'd0)
                && (feb29 ? leap : (day_ff <= {2'b0, month_len(month_ff)}))
                && !(limit_ff && (year_ff >= YEAR_LIMIT));
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_date_valid_in = rsp_date_valid_ff;
      rsp_epoch_in      = rsp_epoch_ff;
      if (fin_go) begin
         rsp_valid_in      = 1'b1;
         rsp_date_valid_in = date_ok;
         rsp_epoch_in      = date_ok ? acc_in[EPOCH_W-1:0] : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WDAY;
         layout_ff    <= LAY_NONE;
         failed_ff    <= 1'b0;
         day_ff       <= '0;
         mon_c0_ff    <= '0;
         mon_c1_ff    <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         limit_ff     <= 1'b0;
         step_ff      <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         layout_ff    <= layout_in;
         failed_ff    <= failed_in;
         day_ff       <= day_in;
         mon_c0_ff    <= mon_c0_in;
         mon_c1_ff    <= mon_c1_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         limit_ff     <= limit_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff           <= prod_in;
      acc_ff            <= acc_in;
      y100_ff           <= y100_in;
      yy100_ff          <= yy100_in;
      cent_ff           <= cent_in;
      rsp_date_valid_ff <= rsp_date_valid_in;
      rsp_epoch_ff      <= rsp_epoch_in;
   end

endmodule

`default_nettype wire

>>> hdl/hdep_checker.sv
// port-level checks for the http date parser, bound to the top level
`default_nettype none

module hdep_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_last_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_date_valid,
   input logic signed [38:0] rsp_epoch_seconds
);

   // a waiting result item holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_date_valid)
                                 && $stable(rsp_epoch_seconds))
      else $error("result item changed while stalled");

   // an invalid date carries zero seconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_valid |-> rsp_epoch_seconds == 39'sd0)
      else $error("invalid result with nonzero seconds");

   // the conversion keeps the input stalled after a last byte
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> req_stall ##1 req_stall)
      else $error("input taken during conversion");

   // a new result only comes out of the conversion sequence
   a_rsp_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without conversion");

   // valid results stay within years 0 to 9999
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_valid |-> rsp_epoch_seconds >= -39'sd62167219200
                                      && rsp_epoch_seconds <= 39'sd253402300799)
      else $error("epoch seconds out of range");

endmodule

bind http_date_to_epoch_parser hdep_checker u_hdep_checker (.*);

`default_nettype wire
